// ===== hw/rtl/ivwm_pkg.sv =====
// ----------------------------------------------------------------------------
// ivwm_pkg
// Widths and the beat structures passed along the cell chains.
// ----------------------------------------------------------------------------
package ivwm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SqW   = 64;
  localparam int unsigned PairW = 128;
  localparam int unsigned TermW = 160;
  localparam int unsigned NumW  = 162;
  localparam int unsigned DenW  = 130;
  localparam int unsigned RemW  = 192;
  localparam int unsigned QW    = 64;

  typedef struct packed {
    logic                    vld;
    logic                    nw;
    logic signed [DataW-1:0] vmin;
    logic [RemW-1:0]         rn;
    logic [RemW-1:0]         rp;
    logic [DenW-1:0]         den;
    logic [QW-1:0]           qn;
    logic [QW-1:0]           qp;
  } ivwm_div_t;

  typedef struct packed {
    logic             vld;
    logic             nw;
    logic [DataW-1:0] mean;
    logic [QW-1:0]    rem;
    logic [DataW-1:0] root;
  } ivwm_sqrt_t;

endpackage

// ===== hw/rtl/ivwm_mul.sv =====
// ----------------------------------------------------------------------------
// ivwm_mul
// Wide multiplier built from registered 32x32 partial products and a registered sum.
// ----------------------------------------------------------------------------
module ivwm_mul #(
  parameter int unsigned AW = 64,
  parameter int unsigned BW = 64
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned LA  = (AW + 31) / 32;
  localparam int unsigned LB  = (BW + 31) / 32;
  localparam int unsigned AXW = 32 * LA;
  localparam int unsigned BXW = 32 * LB;
  localparam int unsigned PW  = AXW + BXW;

  logic [AXW-1:0] a_ext;
  logic [BXW-1:0] b_ext;
  logic [63:0]    pp_q [LA*LB];
  logic [PW-1:0]  acc;
  logic [AW+BW-1:0] p_q;

  assign a_ext = AXW'(a_i);
  assign b_ext = BXW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < int'(LA); i++) begin
        for (int j = 0; j < int'(LB); j++) begin
          pp_q[i*LB+j] <= 64'(a_ext[32*i+:32]) * 64'(b_ext[32*j+:32]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < int'(LA); i++) begin
      for (int j = 0; j < int'(LB); j++) begin
        acc = acc + (PW'(pp_q[i*LB+j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc[AW+BW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/ivwm_div_cell.sv =====
// ----------------------------------------------------------------------------
// ivwm_div_cell
// One restoring division step for both quotients, one quotient bit per cell.
// ----------------------------------------------------------------------------
module ivwm_div_cell import ivwm_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  ivwm_div_t c_i,
  output ivwm_div_t c_o
);

  logic [RemW+1:0] sh;
  logic            ge_n;
  logic            ge_p;
  ivwm_div_t       c_d;
  ivwm_div_t       c_q;

  assign sh   = (RemW+2)'(c_i.den) << K;
  assign ge_n = (RemW+2)'(c_i.rn) >= sh;
  assign ge_p = (RemW+2)'(c_i.rp) >= sh;

  always_comb begin
    c_d = c_i;
    if (ge_n) begin
      c_d.rn    = c_i.rn - sh[RemW-1:0];
      c_d.qn[K] = 1'b1;
    end
    if (ge_p) begin
      c_d.rp    = c_i.rp - sh[RemW-1:0];
      c_d.qp[K] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

// ===== hw/rtl/ivwm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// ivwm_sqrt_cell
// One digit of the integer square root, one root bit per cell.
// ----------------------------------------------------------------------------
module ivwm_sqrt_cell import ivwm_pkg::*; #(
  parameter int unsigned I = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  ivwm_sqrt_t c_i,
  output ivwm_sqrt_t c_o
);

  logic [QW+1:0] test;
  logic          ge;
  ivwm_sqrt_t    c_d;
  ivwm_sqrt_t    c_q;

  assign test = ((QW+2)'(c_i.root) << (I + 1)) + ((QW+2)'(1) << (2 * I));
  assign ge   = (QW+2)'(c_i.rem) >= test;

  always_comb begin
    c_d = c_i;
    if (ge) begin
      c_d.rem     = c_i.rem - test[QW-1:0];
      c_d.root[I] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

// ===== hw/rtl/inverse_variance_weighted_mean3.sv =====
// ----------------------------------------------------------------------------
// inverse_variance_weighted_mean3
// Inverse-variance weighted mean of three values and its uncertainty.
//
//   Channel   Dir  Content
//   s_axis    in   tdata: three values, three uncertainties (192 bits)
//   m_axis    out  tdata: mean, uncertainty; tuser: no-weight flag
//
// One beat is accepted every cycle while the output is not stalled; each
// beat passes the input registers, the multiplier stages, 64 division cells
// and 32 square root cells. Reset clears all valid bits.
// A stalled output freezes the whole chain of cells.
// ----------------------------------------------------------------------------
module inverse_variance_weighted_mean3 import ivwm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // left_value, right_value, center_value, left_sigma, right_sigma, center_sigma
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mean_value, mean_sigma
  output logic [63:0]  m_axis_tdata,
  // no_weight
  output logic [0:0]   m_axis_tuser
);

  logic                    en;
  logic signed [DataW-1:0] v [3];
  logic [DataW-1:0]        s [3];
  logic [2:0]              act;
  logic signed [DataW-1:0] vmin;
  logic                    have;

  logic [5:0]              vld_q;
  logic [SqW-1:0]          sq_q [3];
  logic [DataW-1:0]        d_q [3];
  logic [2:0]              act_q;
  logic signed [DataW-1:0] vmin_q;
  logic                    nw_q;

  logic [PairW-1:0]        pr [3];
  logic [SqW-1:0]          sqa_q [2];
  logic [DataW-1:0]        da_q [2][3];
  logic [2:0]              acta_q [2];
  logic signed [DataW-1:0] vmina_q [2];
  logic                    nwa_q [2];

  logic [TermW-1:0]        tm [3];
  logic [PairW+SqW-1:0]    prod;
  logic [PairW-1:0]        pb_q [2][3];
  logic [2:0]              actb_q [2];
  logic signed [DataW-1:0] vminb_q [2];
  logic                    nwb_q [2];

  logic [NumW-1:0]         num_q;
  logic [DenW-1:0]         den_q;
  logic [RemW-1:0]         prod_q;
  logic signed [DataW-1:0] vmins_q;
  logic                    nws_q;

  ivwm_div_t               dv [65];
  ivwm_sqrt_t              sr [33];
  logic signed [QW+1:0]    t;
  logic signed [QW+1:0]    tr;
  logic [DataW-1:0]        mean;

  assign en            = m_axis_tready | ~m_axis_tvalid;
  assign s_axis_tready = en;

  always_comb begin
    have = 1'b0;
    vmin = '0;
    for (int i = 0; i < 3; i++) begin
      v[i]   = s_axis_tdata[32*i+:32];
      s[i]   = s_axis_tdata[96+32*i+:32];
      act[i] = s[i] != '0;
      if (act[i] && (!have || v[i] < vmin)) begin
        vmin = v[i];
        have = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= act[i] ? SqW'(s[i]) * SqW'(s[i]) : SqW'(1);
        d_q[i]  <= act[i] ? DataW'(v[i] - vmin) : '0;
      end
      act_q  <= act;
      vmin_q <= vmin;
      nw_q   <= ~|act;
    end
  end

  ivwm_mul #(.AW(SqW), .BW(SqW)) u_pa0 (
    .clk_i(clk_i), .en_i(en), .a_i(sq_q[1]), .b_i(sq_q[2]), .p_o(pr[0]));
  ivwm_mul #(.AW(SqW), .BW(SqW)) u_pa1 (
    .clk_i(clk_i), .en_i(en), .a_i(sq_q[0]), .b_i(sq_q[2]), .p_o(pr[1]));
  ivwm_mul #(.AW(SqW), .BW(SqW)) u_pa2 (
    .clk_i(clk_i), .en_i(en), .a_i(sq_q[0]), .b_i(sq_q[1]), .p_o(pr[2]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqa_q[0]   <= sq_q[0];
      sqa_q[1]   <= sqa_q[0];
      da_q[0]    <= d_q;
      da_q[1]    <= da_q[0];
      acta_q[0]  <= act_q;
      acta_q[1]  <= acta_q[0];
      vmina_q[0] <= vmin_q;
      vmina_q[1] <= vmina_q[0];
      nwa_q[0]   <= nw_q;
      nwa_q[1]   <= nwa_q[0];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_term
    ivwm_mul #(.AW(PairW), .BW(DataW)) u_tm (
      .clk_i(clk_i), .en_i(en), .a_i(pr[g]), .b_i(da_q[1][g]), .p_o(tm[g]));
  end

  ivwm_mul #(.AW(PairW), .BW(SqW)) u_prod (
    .clk_i(clk_i), .en_i(en), .a_i(pr[0]), .b_i(sqa_q[1]), .p_o(prod));

  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q[0]    <= pr;
      pb_q[1]    <= pb_q[0];
      actb_q[0]  <= acta_q[1];
      actb_q[1]  <= actb_q[0];
      vminb_q[0] <= vmina_q[1];
      vminb_q[1] <= vminb_q[0];
      nwb_q[0]   <= nwa_q[1];
      nwb_q[1]   <= nwb_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q   <= (actb_q[1][0] ? NumW'(tm[0]) : '0)
               + (actb_q[1][1] ? NumW'(tm[1]) : '0)
               + (actb_q[1][2] ? NumW'(tm[2]) : '0);
      den_q   <= (actb_q[1][0] ? DenW'(pb_q[1][0]) : '0)
               + (actb_q[1][1] ? DenW'(pb_q[1][1]) : '0)
               + (actb_q[1][2] ? DenW'(pb_q[1][2]) : '0);
      prod_q  <= prod;
      vmins_q <= vminb_q[1];
      nws_q   <= nwb_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], s_axis_tvalid};
    end
  end

  always_comb begin
    dv[0]      = '0;
    dv[0].vld  = vld_q[5];
    dv[0].nw   = nws_q;
    dv[0].vmin = vmins_q;
    dv[0].rn   = RemW'(num_q);
    dv[0].rp   = prod_q;
    dv[0].den  = den_q;
  end

  for (genvar g = 0; g < 64; g++) begin : g_div
    ivwm_div_cell #(.K(63 - g)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .c_i(dv[g]), .c_o(dv[g+1]));
  end

  always_comb begin
    t  = (QW+2)'(dv[64].vmin) + $signed({2'b00, dv[64].qn});
    tr = t;
    if (t < 0 && dv[64].rn != '0) begin
      tr = t + 1;
    end
    if (tr > $signed((QW+2)'(32'h7fff_ffff))) begin
      mean = 32'h7fff_ffff;
    end else if (tr < -$signed((QW+2)'(32'h8000_0000))) begin
      mean = 32'h8000_0000;
    end else begin
      mean = tr[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr[0] <= '0;
    end else if (en) begin
      sr[0].vld  <= dv[64].vld;
      sr[0].nw   <= dv[64].nw;
      sr[0].mean <= dv[64].nw ? '0 : mean;
      sr[0].rem  <= dv[64].qp;
      sr[0].root <= '0;
    end
  end

  for (genvar g = 0; g < 32; g++) begin : g_sqrt
    ivwm_sqrt_cell #(.I(31 - g)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .c_i(sr[g]), .c_o(sr[g+1]));
  end

  assign m_axis_tvalid = sr[32].vld;
  assign m_axis_tdata  = {sr[32].nw ? '1 : sr[32].root, sr[32].mean};
  assign m_axis_tuser  = sr[32].nw;

  a_nw_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'hffff_ffff_0000_0000)
    else $error("no-weight beat without fixed result");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  a_feed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted beat lost at chain entry");

endmodule

// ===== sim/inverse_variance_weighted_mean3_test.sv =====
// ----------------------------------------------------------------------------
// inverse_variance_weighted_mean3_test
// Self-checking bench for the three-value inverse-variance weighted mean.
//
// Bins are sent over the input stream, both directed and random ones. Each
// accepted bin is run through an exact wide-integer model of the weighted
// mean and its uncertainty. Every output beat is compared with the oldest
// predicted result. Both stream sides idle at random, except during a long
// calm stretch.
// ----------------------------------------------------------------------------
module inverse_variance_weighted_mean3_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Drain      = 150;

  typedef struct {
    logic signed [31:0] lv, rv, cv;
    logic [31:0]        ls, rs, cs;
  } bin_t;

  typedef struct {
    logic signed [31:0] mean;
    logic [31:0]        sigma;
    logic               nw;
  } wmean_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  wmean_t      pending_means[$];
  int unsigned errors = 0;
  int unsigned bins_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned no_weight_seen = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  inverse_variance_weighted_mean3 i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] root64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  function automatic wmean_t weigh_bin(bin_t b);
    logic signed [63:0] v[3];
    logic [31:0]        s[3];
    logic [255:0]       num, den, prod, p, q, r;
    logic signed [63:0] vmin, t;
    int                 n;
    wmean_t             res;
    v[0] = b.lv; v[1] = b.rv; v[2] = b.cv;
    s[0] = b.ls; s[1] = b.rs; s[2] = b.cs;
    n = 0;
    vmin = 0;
    for (int i = 0; i < 3; i++) begin
      if (s[i] != 0) begin
        if (n == 0 || v[i] < vmin) vmin = v[i];
        n++;
      end
    end
    if (n == 0) begin
      res.mean = '0;
      res.sigma = '1;
      res.nw = 1'b1;
      return res;
    end
    num = '0;
    den = '0;
    prod = 256'd1;
    for (int i = 0; i < 3; i++) begin
      if (s[i] != 0) begin
        prod = prod * 256'(s[i]) * 256'(s[i]);
        p = 256'd1;
        for (int j = 0; j < 3; j++) begin
          if (j != i && s[j] != 0) p = p * 256'(s[j]) * 256'(s[j]);
        end
        den = den + p;
        num = num + p * 256'(unsigned'(v[i] - vmin));
      end
    end
    q = num / den;
    r = num % den;
    t = vmin + $signed(q[63:0]);
    if (t < 0 && r != 0) t = t + 1;
    if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
    if (t < -64'sh80000000) t = -64'sh80000000;
    res.mean = t[31:0];
    res.sigma = root64(64'(prod / den));
    res.nw = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h (beat %0d)", what, got, want, beats_seen);
    errors++;
  endtask

  task automatic send_bin(bin_t b);
    while (!calm && $urandom_range(99) < 8) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata = {b.cs, b.rs, b.ls, b.cv, b.rv, b.lv};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_means.push_back(weigh_bin(b));
    bins_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready = calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin
    wmean_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (pending_means.size() == 0) begin
        $display("Unexpected output beat %0d", beats_seen);
        errors++;
      end else begin
        want = pending_means.pop_front();
        if (m_axis_tdata[31:0] !== want.mean)
          report_mismatch("mean_value", m_axis_tdata[31:0], want.mean);
        if (m_axis_tdata[63:32] !== want.sigma)
          report_mismatch("mean_sigma", m_axis_tdata[63:32], want.sigma);
        if (m_axis_tuser[0] !== want.nw)
          report_mismatch("no_weight", {31'd0, m_axis_tuser[0]}, {31'd0, want.nw});
        if (want.nw) no_weight_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bin_t make_bin(logic [31:0] lv, logic [31:0] rv, logic [31:0] cv,
                                    logic [31:0] ls, logic [31:0] rs, logic [31:0] cs);
    bin_t b;
    b.lv = lv; b.rv = rv; b.cv = cv;
    b.ls = ls; b.rs = rs; b.cs = cs;
    return b;
  endfunction

  function automatic logic [31:0] rand_sigma();
    case ($urandom_range(3))
      0: return '0;
      1: return $urandom_range(65535, 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(255) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_no_weight();
    send_bin(make_bin(0, 0, 0, 0, 0, 0));
    send_bin(make_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 0, 0, 0));
    send_bin(make_bin('1, '1, '1, 0, 0, 0));
  endtask

  task automatic test_unweighted_values();
    send_bin(make_bin(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0));
    send_bin(make_bin(32'h8000_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 0, 32'h0002_0000, 0));
    send_bin(make_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 32'd1));
    send_bin(make_bin(32'h0003_0000, 32'h8000_0000, 32'hFFFE_0000, 32'd1, 0, '1));
  endtask

  task automatic test_extremes();
    send_bin(make_bin(32'h7FFF_FFFF, 32'h8000_0000, 0, '1, '1, '1));
    send_bin(make_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1));
    send_bin(make_bin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, 32'd1, 32'd1));
    send_bin(make_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, '1, '1));
    send_bin(make_bin(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001, 32'd3, 32'd5, 32'd7));
    send_bin(make_bin(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                      32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_bin(make_bin(32'hFFFF_8000, 32'h0000_8000, 0, 32'h0000_8000, 32'h0000_8000, 0));
    send_bin(make_bin(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000));
  endtask

  task automatic test_random_bins(int unsigned count);
    for (int unsigned k = 0; k < count; k++)
      send_bin(make_bin(rand_value(), rand_value(), rand_value(),
                        rand_sigma(), rand_sigma(), rand_sigma()));
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_no_weight();
    test_unweighted_values();
    test_extremes();
    test_random_bins(800);
    calm = 1'b1;
    test_random_bins(400);
    calm = 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    $display("Sent %0d bins and checked %0d result beats, %0d of them without weight.",
             bins_sent, beats_seen, no_weight_seen);
    $display("Random stalls on both sides, with a calm stretch of back-to-back beats.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
